// ----- design/rmq_pkg.sv -----
package rmq_pkg;

    typedef logic [1:0] branch_t;

    localparam branch_t BR_TRACE = 2'd0;
    localparam branch_t BR_R11   = 2'd1;
    localparam branch_t BR_R22   = 2'd2;
    localparam branch_t BR_R00   = 2'd3;

    localparam int QUOT_BITS = 16;

    localparam logic [15:0] OUT_MAX = 16'h7fff;
    localparam logic [15:0] OUT_MIN = 16'h8000;

endpackage

// ----- design/rotation_matrix_to_quaternion.sv -----
// channel | handshake             | payload
// matrix  | mat_valid / mat_stall | r00 r01 r02 r10 r11 r12 r20 r21 r22
// quat    | quat_valid/ quat_stall| quat_w quat_x quat_y quat_z branch_taken
//
// One beat per cycle while not stalled; RW = root width (16 at FRAC_BITS = 14). A beat passes
// through the root pipeline (one root bit per stage), the 16-stage divider and the output
// registers.
// rst_n clears all valid bits at once; payload registers are not reset.
// quat_stall with a waiting result freezes the whole pipeline, mat_stall follows.
module rotation_matrix_to_quaternion #(
    parameter int FRAC_BITS = 14
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               mat_valid,
    output logic               mat_stall,
    input  logic signed [15:0] r00,
    input  logic signed [15:0] r01,
    input  logic signed [15:0] r02,
    input  logic signed [15:0] r10,
    input  logic signed [15:0] r11,
    input  logic signed [15:0] r12,
    input  logic signed [15:0] r20,
    input  logic signed [15:0] r21,
    input  logic signed [15:0] r22,
    output logic               quat_valid,
    input  logic               quat_stall,
    output logic signed [15:0] quat_w,
    output logic signed [15:0] quat_x,
    output logic signed [15:0] quat_y,
    output logic signed [15:0] quat_z,
    output logic [1:0]         branch_taken
);

    localparam int AW  = ((FRAC_BITS + 2 > 18) ? FRAC_BITS + 2 : 18) + 1;
    localparam int VW0 = AW - 1 + FRAC_BITS;
    localparam int RW  = (VW0 + 1) / 2;
    localparam int VW  = 2 * RW;
    localparam int QB  = rmq_pkg::QUOT_BITS;
    localparam int NW  = ((FRAC_BITS > RW) ? FRAC_BITS : RW) + 18;
    localparam int MW  = RW + 16;

    logic en;
    logic quat_valid_reg;

    assign en        = !(quat_valid_reg && quat_stall);
    assign mat_stall = !en;

    // front: branch select, root argument, off-diagonal sums and differences
    logic signed [AW-1:0] e00, e11, e22, one_w, tr, arg;
    logic [AW-2:0]        arg_pos;
    rmq_pkg::branch_t     br_front;
    logic signed [16:0]   nf [3];

    always_comb
    begin
        e00   = AW'(r00);
        e11   = AW'(r11);
        e22   = AW'(r22);
        one_w = AW'(1) << FRAC_BITS;
        tr    = e00 + e11 + e22;
        if (tr > 0)
        begin
            br_front = rmq_pkg::BR_TRACE;
            arg      = tr + one_w;
            nf[0]    = 17'(r12) - 17'(r21);
            nf[1]    = 17'(r20) - 17'(r02);
            nf[2]    = 17'(r01) - 17'(r10);
        end
        else if (r11 > r00 && r11 > r22)
        begin
            br_front = rmq_pkg::BR_R11;
            arg      = e11 - e00 - e22 + one_w;
            nf[0]    = 17'(r20) - 17'(r02);
            nf[1]    = 17'(r01) + 17'(r10);
            nf[2]    = 17'(r12) + 17'(r21);
        end
        else if (r22 > r00)
        begin
            br_front = rmq_pkg::BR_R22;
            arg      = e22 - e00 - e11 + one_w;
            nf[0]    = 17'(r01) - 17'(r10);
            nf[1]    = 17'(r20) + 17'(r02);
            nf[2]    = 17'(r12) + 17'(r21);
        end
        else
        begin
            br_front = rmq_pkg::BR_R00;
            arg      = e00 - e11 - e22 + one_w;
            nf[0]    = 17'(r12) - 17'(r21);
            nf[1]    = 17'(r01) + 17'(r10);
            nf[2]    = 17'(r20) + 17'(r02);
        end
        arg_pos = arg[AW-1] ? '0 : arg[AW-2:0];
    end

    // root pipeline, one root bit per stage
    logic                 sq_v_reg    [0:RW];
    logic [VW-1:0]        sq_rad_reg  [0:RW];
    logic [RW-1:0]        sq_rem_reg  [0:RW];
    logic [RW-1:0]        sq_root_reg [0:RW];
    rmq_pkg::branch_t     sq_br_reg   [0:RW];
    logic signed [16:0]   sq_n_reg    [0:RW][3];

    logic [RW+1:0] rem_sh   [RW];
    logic [RW+1:0] trial    [RW];
    logic          sq_ge    [RW];
    logic [RW-1:0] rem_next [RW];

    always_comb
    begin
        for (int j = 0; j < RW; j++)
        begin
            rem_sh[j]   = {sq_rem_reg[j], sq_rad_reg[j][VW-1 -: 2]};
            trial[j]    = {sq_root_reg[j], 2'b01};
            sq_ge[j]    = rem_sh[j] >= trial[j];
            rem_next[j] = sq_ge[j] ? RW'(rem_sh[j] - trial[j]) : rem_sh[j][RW-1:0];
        end
    end

    // divider prep
    logic [RW-1:0]   s_fin;
    logic [RW:0]     main_full;
    logic [15:0]     main_sat;
    logic            neg_p [3];
    logic [16:0]     mag_p [3];
    logic [NW-1:0]   num_p [3];
    logic            ovf_p [3];

    always_comb
    begin
        s_fin     = sq_root_reg[RW];
        main_full = ({1'b0, s_fin} + (RW+1)'(1)) >> 1;
        main_sat  = (MW'(main_full) > MW'(rmq_pkg::OUT_MAX)) ? rmq_pkg::OUT_MAX
                                                             : 16'(main_full);
        for (int l = 0; l < 3; l++)
        begin
            neg_p[l] = sq_n_reg[RW][l][16];
            mag_p[l] = neg_p[l] ? (~sq_n_reg[RW][l] + 17'd1) : sq_n_reg[RW][l];
            num_p[l] = (NW'(mag_p[l]) << FRAC_BITS) + NW'(s_fin);
            ovf_p[l] = num_p[l] >= (NW'(s_fin) << (QB + 1));
        end
    end

    // restoring divider, one quotient bit per stage
    logic              dv_v_reg    [0:QB];
    logic [NW-1:0]     dv_rem_reg  [0:QB][3];
    logic [QB-1:0]     dv_q_reg    [0:QB][3];
    logic              dv_neg_reg  [0:QB][3];
    logic              dv_ovf_reg  [0:QB][3];
    logic              dv_zero_reg [0:QB];
    logic [RW-1:0]     dv_s_reg    [0:QB];
    logic [15:0]       dv_main_reg [0:QB];
    rmq_pkg::branch_t  dv_br_reg   [0:QB];

    logic [NW-1:0] dsh     [QB][3];
    logic          dv_ge   [QB][3];
    logic [NW-1:0] dv_rem_next [QB][3];
    logic [QB-1:0] dv_q_next   [QB][3];

    always_comb
    begin
        for (int k = 0; k < QB; k++)
        begin
            for (int l = 0; l < 3; l++)
            begin
                dsh[k][l]         = NW'(dv_s_reg[k]) << (QB - k);
                dv_ge[k][l]       = dv_rem_reg[k][l] >= dsh[k][l];
                dv_rem_next[k][l] = dv_ge[k][l] ? dv_rem_reg[k][l] - dsh[k][l]
                                                : dv_rem_reg[k][l];
                dv_q_next[k][l]   = dv_q_reg[k][l];
                dv_q_next[k][l][QB-1-k] = dv_ge[k][l];
            end
        end
    end

    // final saturation and component placement
    logic [15:0] oth [3];
    logic [15:0] qw_next, qx_next, qy_next, qz_next;

    always_comb
    begin
        for (int l = 0; l < 3; l++)
        begin
            if (dv_zero_reg[QB])
                oth[l] = '0;
            else if (dv_neg_reg[QB][l])
                oth[l] = (dv_ovf_reg[QB][l] || dv_q_reg[QB][l] > 16'd32768)
                       ? rmq_pkg::OUT_MIN : (~dv_q_reg[QB][l] + 16'd1);
            else
                oth[l] = (dv_ovf_reg[QB][l] || dv_q_reg[QB][l] > 16'd32767)
                       ? rmq_pkg::OUT_MAX : dv_q_reg[QB][l];
        end
        case (dv_br_reg[QB])
            rmq_pkg::BR_TRACE:
            begin
                qw_next = dv_main_reg[QB];
                qx_next = oth[0];
                qy_next = oth[1];
                qz_next = oth[2];
            end
            rmq_pkg::BR_R11:
            begin
                qw_next = oth[0];
                qx_next = oth[1];
                qy_next = dv_main_reg[QB];
                qz_next = oth[2];
            end
            rmq_pkg::BR_R22:
            begin
                qw_next = oth[0];
                qx_next = oth[1];
                qy_next = oth[2];
                qz_next = dv_main_reg[QB];
            end
            default:
            begin
                qw_next = oth[0];
                qx_next = dv_main_reg[QB];
                qy_next = oth[1];
                qz_next = oth[2];
            end
        endcase
    end

    logic [15:0]      qw_reg, qx_reg, qy_reg, qz_reg;
    rmq_pkg::branch_t br_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int j = 0; j <= RW; j++)
                sq_v_reg[j] <= 1'b0;
            for (int k = 0; k <= QB; k++)
                dv_v_reg[k] <= 1'b0;
            quat_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            sq_v_reg[0] <= mat_valid;
            for (int j = 0; j < RW; j++)
                sq_v_reg[j+1] <= sq_v_reg[j];
            dv_v_reg[0] <= sq_v_reg[RW];
            for (int k = 0; k < QB; k++)
                dv_v_reg[k+1] <= dv_v_reg[k];
            quat_valid_reg <= dv_v_reg[QB];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sq_rad_reg[0]  <= VW'({arg_pos, {FRAC_BITS{1'b0}}});
            sq_rem_reg[0]  <= '0;
            sq_root_reg[0] <= '0;
            sq_br_reg[0]   <= br_front;
            for (int l = 0; l < 3; l++)
                sq_n_reg[0][l] <= nf[l];
            for (int j = 0; j < RW; j++)
            begin
                sq_rad_reg[j+1]  <= sq_rad_reg[j] << 2;
                sq_rem_reg[j+1]  <= rem_next[j];
                sq_root_reg[j+1] <= {sq_root_reg[j][RW-2:0], sq_ge[j]};
                sq_br_reg[j+1]   <= sq_br_reg[j];
                for (int l = 0; l < 3; l++)
                    sq_n_reg[j+1][l] <= sq_n_reg[j][l];
            end

            dv_zero_reg[0] <= (s_fin == '0);
            dv_s_reg[0]    <= s_fin;
            dv_main_reg[0] <= main_sat;
            dv_br_reg[0]   <= sq_br_reg[RW];
            for (int l = 0; l < 3; l++)
            begin
                dv_rem_reg[0][l] <= num_p[l];
                dv_q_reg[0][l]   <= '0;
                dv_neg_reg[0][l] <= neg_p[l];
                dv_ovf_reg[0][l] <= ovf_p[l];
            end
            for (int k = 0; k < QB; k++)
            begin
                dv_zero_reg[k+1] <= dv_zero_reg[k];
                dv_s_reg[k+1]    <= dv_s_reg[k];
                dv_main_reg[k+1] <= dv_main_reg[k];
                dv_br_reg[k+1]   <= dv_br_reg[k];
                for (int l = 0; l < 3; l++)
                begin
                    dv_rem_reg[k+1][l] <= dv_rem_next[k][l];
                    dv_q_reg[k+1][l]   <= dv_q_next[k][l];
                    dv_neg_reg[k+1][l] <= dv_neg_reg[k][l];
                    dv_ovf_reg[k+1][l] <= dv_ovf_reg[k][l];
                end
            end

            qw_reg <= qw_next;
            qx_reg <= qx_next;
            qy_reg <= qy_next;
            qz_reg <= qz_next;
            br_reg <= dv_br_reg[QB];
        end
    end

    assign quat_valid   = quat_valid_reg;
    assign quat_w       = qw_reg;
    assign quat_x       = qx_reg;
    assign quat_y       = qy_reg;
    assign quat_z       = qz_reg;
    assign branch_taken = br_reg;

    // main component is a half root and never negative
    a_main_w: assert property (@(posedge clk) disable iff (!rst_n)
        quat_valid && branch_taken == rmq_pkg::BR_TRACE |-> !quat_w[15])
        else $error("negative w on trace branch");

    a_main_y: assert property (@(posedge clk) disable iff (!rst_n)
        quat_valid && branch_taken == rmq_pkg::BR_R11 |-> !quat_y[15])
        else $error("negative y on r11 branch");

    a_main_x: assert property (@(posedge clk) disable iff (!rst_n)
        quat_valid && branch_taken == rmq_pkg::BR_R00 |-> !quat_x[15])
        else $error("negative x on r00 branch");

endmodule

// ----- dv/rotation_matrix_to_quaternion_tb.sv -----
`timescale 1ns / 1ps

module rotation_matrix_to_quaternion_tb;

    localparam int FRAC = 14;
    localparam int ONE = 1 << FRAC;
    localparam int LATENCY = 35;
    localparam int N_RANDOM = 1630;
    localparam longint CYCLE_LIMIT = 400000;

    typedef struct packed {
        logic signed [15:0] m00, m01, m02, m10, m11, m12, m20, m21, m22;
    } matrix_t;

    typedef struct packed {
        logic signed [15:0] w, x, y, z;
        rmq_pkg::branch_t br;
    } quat_t;

    typedef struct {
        matrix_t m;
        logic known;
        quat_t q;
    } row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic mat_valid = 1'b0;
    logic mat_stall;
    logic signed [15:0] r00 = '0, r01 = '0, r02 = '0, r10 = '0, r11 = '0, r12 = '0;
    logic signed [15:0] r20 = '0, r21 = '0, r22 = '0;
    logic quat_valid;
    logic quat_stall = 1'b0;
    logic signed [15:0] quat_w, quat_x, quat_y, quat_z;
    logic [1:0] branch_taken;

    quat_t pending_quats[$];
    int mismatches = 0;
    int send_idle_pct = 9;
    int recv_idle_pct = 57;
    logic hold_start = 1'b0;
    logic hold_recv = 1'b0;
    longint cycles = 0;

    rotation_matrix_to_quaternion dut (
        .clk(clk), .rst_n(rst_n),
        .mat_valid(mat_valid), .mat_stall(mat_stall),
        .r00(r00), .r01(r01), .r02(r02), .r10(r10), .r11(r11), .r12(r12),
        .r20(r20), .r21(r21), .r22(r22),
        .quat_valid(quat_valid), .quat_stall(quat_stall),
        .quat_w(quat_w), .quat_x(quat_x), .quat_y(quat_y), .quat_z(quat_z),
        .branch_taken(branch_taken)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    function automatic longint unsigned int_sqrt(longint unsigned v);
        longint unsigned res, bitv;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > v)
            bitv >>= 2;
        while (bitv != 0)
        begin
            if (v >= res + bitv)
            begin
                v -= res + bitv;
                res = (res >> 1) + bitv;
            end
            else
                res >>= 1;
            bitv >>= 2;
        end
        return res;
    endfunction

    function automatic logic signed [15:0] clamp16(longint v);
        if (v > 32767)
            return 16'sh7fff;
        if (v < -32768)
            return 16'sh8000;
        return v[15:0];
    endfunction

    function automatic longint div_by_root(longint n, longint unsigned root);
        longint unsigned den, mag, q;
        if (root == 0)
            return 0;
        den = root * 2;
        mag = (n < 0 ? -n : n) << FRAC;
        q = (mag + den / 2) / den;
        return n < 0 ? -longint'(q) : longint'(q);
    endfunction

    function automatic quat_t matrix_to_quat(matrix_t m);
        longint a00, a01, a02, a10, a11, a12, a20, a21, a22, tr, arg, mn;
        longint n0, n1, n2, w, x, y, z;
        longint unsigned root;
        quat_t q;
        a00 = m.m00; a01 = m.m01; a02 = m.m02;
        a10 = m.m10; a11 = m.m11; a12 = m.m12;
        a20 = m.m20; a21 = m.m21; a22 = m.m22;
        tr = a00 + a11 + a22;
        if (tr > 0)
        begin
            q.br = rmq_pkg::BR_TRACE; arg = tr + ONE;
        end
        else if (a11 > a00 && a11 > a22)
        begin
            q.br = rmq_pkg::BR_R11; arg = a11 - a00 - a22 + ONE;
        end
        else if (a22 > a00)
        begin
            q.br = rmq_pkg::BR_R22; arg = a22 - a00 - a11 + ONE;
        end
        else
        begin
            q.br = rmq_pkg::BR_R00; arg = a00 - a11 - a22 + ONE;
        end
        if (arg < 0)
            arg = 0;
        root = int_sqrt(longint'(arg) << FRAC);
        mn = longint'((root + 1) >> 1);
        case (q.br)
            rmq_pkg::BR_TRACE:
            begin
                n0 = a12 - a21; n1 = a20 - a02; n2 = a01 - a10;
                w = mn; x = div_by_root(n0, root);
                y = div_by_root(n1, root); z = div_by_root(n2, root);
            end
            rmq_pkg::BR_R11:
            begin
                n0 = a20 - a02; n1 = a01 + a10; n2 = a12 + a21;
                y = mn; w = div_by_root(n0, root);
                x = div_by_root(n1, root); z = div_by_root(n2, root);
            end
            rmq_pkg::BR_R22:
            begin
                n0 = a01 - a10; n1 = a20 + a02; n2 = a12 + a21;
                z = mn; w = div_by_root(n0, root);
                x = div_by_root(n1, root); y = div_by_root(n2, root);
            end
            default:
            begin
                n0 = a12 - a21; n1 = a01 + a10; n2 = a20 + a02;
                x = mn; w = div_by_root(n0, root);
                y = div_by_root(n1, root); z = div_by_root(n2, root);
            end
        endcase
        q.w = clamp16(w); q.x = clamp16(x); q.y = clamp16(y); q.z = clamp16(z);
        return q;
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        mismatches++;
    endtask

    function automatic logic signed [15:0] rand_entry();
        case ($urandom_range(0, 5))
            0: return 16'($urandom);
            1: return $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
            default: return 16'(int'($urandom_range(0, 2 * ONE)) - ONE);
        endcase
    endfunction

    function automatic matrix_t rand_matrix();
        matrix_t m;
        int ang, axis;
        real c, s;
        m = '0;
        if ($urandom_range(0, 3) == 0)
        begin
            m.m00 = rand_entry(); m.m01 = rand_entry(); m.m02 = rand_entry();
            m.m10 = rand_entry(); m.m11 = rand_entry(); m.m12 = rand_entry();
            m.m20 = rand_entry(); m.m21 = rand_entry(); m.m22 = rand_entry();
        end
        else
        begin
            ang = $urandom_range(0, 6283);
            c = $cos(ang / 1000.0) * ONE;
            s = $sin(ang / 1000.0) * ONE;
            axis = $urandom_range(0, 2);
            m.m00 = 16'(ONE); m.m11 = 16'(ONE); m.m22 = 16'(ONE);
            if (axis == 0)
            begin
                m.m11 = 16'($rtoi(c)); m.m22 = 16'($rtoi(c));
                m.m12 = 16'(-$rtoi(s)); m.m21 = 16'($rtoi(s));
            end
            else if (axis == 1)
            begin
                m.m00 = 16'($rtoi(c)); m.m22 = 16'($rtoi(c));
                m.m02 = 16'($rtoi(s)); m.m20 = 16'(-$rtoi(s));
            end
            else
            begin
                m.m00 = 16'($rtoi(c)); m.m11 = 16'($rtoi(c));
                m.m01 = 16'(-$rtoi(s)); m.m10 = 16'($rtoi(s));
            end
        end
        return m;
    endfunction

    task automatic send_matrix(matrix_t m);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            mat_valid <= 1'b0;
            @(posedge clk);
        end
        mat_valid <= 1'b1;
        {r00, r01, r02, r10, r11, r12, r20, r21, r22} <= m;
        pending_quats.push_back(matrix_to_quat(m));
        @(posedge clk);
        while (mat_stall)
            @(posedge clk);
    endtask

    always @(posedge clk)
    begin
        if (rst_n)
            quat_stall <= hold_recv || ($urandom_range(0, 99) < recv_idle_pct);
    end

    always @(posedge clk)
    begin
        quat_t want;
        if (rst_n && quat_valid && !quat_stall)
        begin
            if (pending_quats.size() == 0)
                report_mismatch("unexpected beat", quat_w, 0);
            else
            begin
                want = pending_quats.pop_front();
                if (quat_w !== want.w) report_mismatch("quat_w", quat_w, want.w);
                if (quat_x !== want.x) report_mismatch("quat_x", quat_x, want.x);
                if (quat_y !== want.y) report_mismatch("quat_y", quat_y, want.y);
                if (quat_z !== want.z) report_mismatch("quat_z", quat_z, want.z);
                if (branch_taken !== want.br)
                    report_mismatch("branch_taken", branch_taken, want.br);
            end
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    row_t directed [19] = '{
        '{'{ONE, 0, 0, 0, ONE, 0, 0, 0, ONE}, 1'b1,
          '{16'sd16384, 0, 0, 0, rmq_pkg::BR_TRACE}},
        '{'{0, 0, 0, 0, 0, 0, 0, 0, 0}, 1'b1, '{0, 16'sd8192, 0, 0, rmq_pkg::BR_R00}},
        '{'{-ONE, 0, 0, 0, ONE, 0, 0, 0, -ONE}, 1'b1,
          '{0, 0, 16'sd16384, 0, rmq_pkg::BR_R11}},
        '{'{-ONE, 0, 0, 0, -ONE, 0, 0, 0, ONE}, 1'b1,
          '{0, 0, 0, 16'sd16384, rmq_pkg::BR_R22}},
        '{'{ONE, 0, 0, 0, -ONE, 0, 0, 0, -ONE}, 1'b1,
          '{0, 16'sd16384, 0, 0, rmq_pkg::BR_R00}},
        '{'{-32768, 0, 0, 0, 32767, 0, 0, 0, 32767}, 1'b0, '0},
        '{'{-ONE, 32767, -32768, 32767, -ONE, -32768, 32767, -32768, -ONE}, 1'b0, '0},
        '{'{32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767}, 1'b0, '0},
        '{'{-32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768},
          1'b0, '0},
        '{'{-32768, 100, -100, 200, -32768, 5, 7, 9, -32768}, 1'b0, '0},
        '{'{0, 0, 0, 0, 0, 0, 0, 0, -ONE}, 1'b0, '0},
        '{'{-100, 0, 0, 0, -100, 0, 0, 0, -100}, 1'b0, '0},
        '{'{-ONE, 0, 0, 0, 0, 0, 0, 0, 0}, 1'b0, '0},
        '{'{0, ONE, 0, -ONE, 0, 0, 0, 0, 0}, 1'b0, '0},
        '{'{0, 0, -ONE, 0, ONE, 0, ONE, 0, -ONE}, 1'b0, '0},
        '{'{-32768, 1, 2, 3, -32768, 4, 5, 6, 0}, 1'b0, '0},
        '{'{1, -32768, 32767, 32767, 0, -32768, -32768, 32767, 0}, 1'b0, '0},
        '{'{16'sh5555, 16'shaaaa, 16'sh5555, 16'shaaaa, 16'sh5555, 16'shaaaa,
            16'sh5555, 16'shaaaa, 16'sh5555}, 1'b0, '0},
        '{'{16'shaaaa, 16'sh5555, 16'shaaaa, 16'sh5555, 16'shaaaa, 16'sh5555,
            16'shaaaa, 16'sh5555, 16'shaaaa}, 1'b0, '0}
    };

    initial
    begin
        int i, phase;
        quat_t want;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        foreach (directed[k])
        begin
            if (directed[k].known)
            begin
                want = matrix_to_quat(directed[k].m);
                if (want !== directed[k].q)
                    report_mismatch("directed row", k, directed[k].q.br);
            end
            send_matrix(directed[k].m);
        end
        for (phase = 0; phase < 3; phase++)
        begin
            send_idle_pct = (phase == 0) ? 9 : (phase == 1) ? 57 : 0;
            recv_idle_pct = (phase == 0) ? 57 : (phase == 1) ? 9 : 0;
            for (i = 0; i < N_RANDOM / 3; i++)
            begin
                if (phase == 2 && i == 40)
                    hold_start <= 1'b1;
                if (phase == 2 && i == 200)
                begin
                    mat_valid <= 1'b0;
                    while (pending_quats.size() != 0)
                        @(posedge clk);
                end
                send_matrix(rand_matrix());
            end
        end
        mat_valid <= 1'b0;
        while (pending_quats.size() != 0)
            @(posedge clk);
        repeat (LATENCY + 10) @(posedge clk);
        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    initial
    begin
        int n;
        wait (hold_start);
        hold_recv <= 1'b1;
        n = 0;
        while (n < 300)
        begin
            @(posedge clk);
            n++;
        end
        hold_recv <= 1'b0;
    end
endmodule
